### hw/rtl/bmg_pkg.sv
package bmg_pkg;

    localparam int IN_FRAC_BITS  = 32;
    localparam int OUT_FRAC_BITS = 12;

    // q28 / q30 constants
    localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    // rounding point of r (q28) times cos (q30)
    localparam int SCALE_SH = 58 - OUT_FRAC_BITS;

    // divide by a constant as multiply by ceil(2^s/d) then shift by s, s = 30 + clog2(d)
    localparam int COS_S [5] = '{37, 36, 35, 34, 31};
    localparam logic [30:0] COS_M [5] = '{
        31'(((64'd1 << 37) + 64'd89) / 64'd90),
        31'(((64'd1 << 36) + 64'd55) / 64'd56),
        31'(((64'd1 << 35) + 64'd29) / 64'd30),
        31'(((64'd1 << 34) + 64'd11) / 64'd12),
        31'(((64'd1 << 31) + 64'd1) / 64'd2)
    };
    localparam int SIN_S [4] = '{37, 36, 35, 33};
    localparam logic [30:0] SIN_M [4] = '{
        31'(((64'd1 << 37) + 64'd71) / 64'd72),
        31'(((64'd1 << 36) + 64'd41) / 64'd42),
        31'(((64'd1 << 35) + 64'd19) / 64'd20),
        31'(((64'd1 << 33) + 64'd5) / 64'd6)
    };

    // pipeline depths
    localparam int LOG_LAT   = 31;
    localparam int SQRT_LAT  = 32;
    localparam int COS_LAT   = 14;
    localparam int ALIGN_LAT = LOG_LAT + SQRT_LAT - COS_LAT;

    typedef struct packed {
        logic        valid;
        logic [31:0] x;
    } bmg_in_t;

    typedef struct packed {
        logic        valid;
        logic [34:0] r2;
    } bmg_r2_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] root;
    } bmg_root_t;

    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } bmg_cos_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] value;
    } bmg_res_t;

endpackage

### hw/rtl/bmg_log_unit.sv
module bmg_log_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  bmg_pkg::bmg_in_t in_item,
    output bmg_pkg::bmg_r2_t out_item
);
    import bmg_pkg::*;

    localparam int NSQ = 28;

    logic        valid_reg [0:NSQ+2];
    logic [28:0] m_reg     [0:NSQ];
    logic [27:0] frac_reg  [0:NSQ];
    logic [4:0]  e_reg     [0:NSQ];
    logic [33:0] len_reg;
    logic [34:0] r2_reg;

    logic [4:0]  e_next;
    logic [31:0] sh_next;

    // index of the top set bit
    always_comb begin
        e_next = '0;
        for (int b = 0; b < 32; b++) begin
            if (in_item.x[b]) e_next = 5'(b);
        end
        if (e_next <= 5'd28) sh_next = in_item.x << (5'd28 - e_next);
        else                 sh_next = in_item.x >> (e_next - 5'd28);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NSQ + 2; k++) valid_reg[k] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_item.valid;
            for (int k = 1; k <= NSQ + 2; k++) valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0]    <= sh_next[28:0];
            frac_reg[0] <= '0;
            e_reg[0]    <= e_next;
        end
    end

    // one squaring per stage, one fraction bit of log2 per stage
    for (genvar i = 1; i <= NSQ; i++) begin : g_sq
        logic [57:0] sq_next;
        logic [29:0] mm_next;
        assign sq_next = 58'(m_reg[i-1]) * 58'(m_reg[i-1]);
        assign mm_next = sq_next[57:28];
        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[i]    <= mm_next[29] ? mm_next[29:1] : mm_next[28:0];
                frac_reg[i] <= frac_reg[i-1] | (28'(mm_next[29]) << (NSQ - i));
                e_reg[i]    <= e_reg[i-1];
            end
        end
    end

    logic [62:0] r2_prod_next;
    assign r2_prod_next = 63'(len_reg) * 63'(TWO_LN2_Q28);

    always_ff @(posedge aclk) begin
        if (en) begin
            len_reg <= (34'(7'(IN_FRAC_BITS) - 7'(e_reg[NSQ])) << 28) - 34'(frac_reg[NSQ]);
            r2_reg  <= 35'(r2_prod_next >> 28);
        end
    end

    assign out_item.valid = valid_reg[NSQ+2];
    assign out_item.r2    = r2_reg;

endmodule

### hw/rtl/bmg_sqrt_unit.sv
module bmg_sqrt_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  bmg_pkg::bmg_r2_t   in_item,
    output bmg_pkg::bmg_root_t out_item
);
    import bmg_pkg::*;

    logic        valid_reg [0:SQRT_LAT-1];
    logic [32:0] rem_reg   [0:SQRT_LAT-1];
    logic [31:0] root_reg  [0:SQRT_LAT-1];
    logic [63:0] rest_reg  [0:SQRT_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SQRT_LAT; k++) valid_reg[k] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_item.valid;
            for (int k = 1; k < SQRT_LAT; k++) valid_reg[k] <= valid_reg[k-1];
        end
    end

    // two radicand bits and one root bit per stage
    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
        logic [32:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rest_in;
        logic [34:0] cand_next;
        logic [34:0] trial_next;
        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rest_in = 64'(in_item.r2) << 28;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rest_in = rest_reg[k-1];
        end
        assign cand_next  = {rem_in, rest_in[63:62]};
        assign trial_next = {1'b0, root_in, 2'b01};
        always_ff @(posedge aclk) begin
            if (en) begin
                if (cand_next >= trial_next) begin
                    rem_reg[k]  <= 33'(cand_next - trial_next);
                    root_reg[k] <= {root_in[30:0], 1'b1};
                end else begin
                    rem_reg[k]  <= cand_next[32:0];
                    root_reg[k] <= {root_in[30:0], 1'b0};
                end
                rest_reg[k] <= rest_in << 2;
            end
        end
    end

    assign out_item.valid = valid_reg[SQRT_LAT-1];
    assign out_item.root  = root_reg[SQRT_LAT-1];

endmodule

### hw/rtl/bmg_cos_unit.sv
module bmg_cos_unit (
    input  logic              aclk,
    input  logic              en,
    input  logic [31:0]       angle,
    output bmg_pkg::bmg_cos_t out_cos
);
    import bmg_pkg::*;

    typedef struct packed {
        logic [1:0]  q;
        logic        swap;
        logic [29:0] t;
        logic [29:0] t2;
    } ang_t;

    logic [1:0]  q0_reg, q1_reg;
    logic        swap0_reg, swap1_reg;
    logic [29:0] g0_reg, t1_reg;
    ang_t        ang_reg [0:10];
    logic [29:0] cy_reg  [0:4];
    logic [30:0] ch_reg  [1:5];
    logic [29:0] sy_reg  [0:3];
    logic [30:0] sh_reg  [1:4];
    logic [30:0] sfin_reg, spad_reg;
    bmg_cos_t    out_reg;

    logic [29:0] f_next;
    logic [61:0] tp_next;
    logic [59:0] t2p_next;

    assign f_next   = angle[29:0];
    assign tp_next  = 62'(g0_reg) * 62'(PI_Q30);
    assign t2p_next = 60'(t1_reg) * 60'(t1_reg);

    // fold to the first octant, t in q30 radians
    always_ff @(posedge aclk) begin
        if (en) begin
            q0_reg    <= angle[31:30];
            swap0_reg <= f_next[29];
            g0_reg    <= f_next[29] ? 30'(Q30_ONE - 31'(f_next)) : f_next;
            q1_reg    <= q0_reg;
            swap1_reg <= swap0_reg;
            t1_reg    <= 30'(tp_next >> 31);
            ang_reg[0] <= '{q: q1_reg, swap: swap1_reg, t: t1_reg,
                            t2: 30'(t2p_next >> 30)};
            for (int j = 1; j <= 10; j++) ang_reg[j] <= ang_reg[j-1];
        end
    end

    // cosine horner chain, two stages per term
    for (genvar k = 0; k < 5; k++) begin : g_cos
        logic [30:0] h_in;
        logic [60:0] yp_next;
        logic [60:0] qp_next;
        if (k == 0) begin : g_first
            assign h_in = Q30_ONE;
        end else begin : g_rest
            assign h_in = ch_reg[k];
        end
        assign yp_next = 61'(ang_reg[2*k].t2) * 61'(h_in);
        assign qp_next = 61'(cy_reg[k]) * 61'(COS_M[k]);
        always_ff @(posedge aclk) begin
            if (en) begin
                cy_reg[k]   <= 30'(yp_next >> 30);
                ch_reg[k+1] <= Q30_ONE - 31'(30'(qp_next >> COS_S[k]));
            end
        end
    end

    // sine horner chain
    for (genvar k = 0; k < 4; k++) begin : g_sin
        logic [30:0] h_in;
        logic [60:0] yp_next;
        logic [60:0] qp_next;
        if (k == 0) begin : g_first
            assign h_in = Q30_ONE;
        end else begin : g_rest
            assign h_in = sh_reg[k];
        end
        assign yp_next = 61'(ang_reg[2*k].t2) * 61'(h_in);
        assign qp_next = 61'(sy_reg[k]) * 61'(SIN_M[k]);
        always_ff @(posedge aclk) begin
            if (en) begin
                sy_reg[k]   <= 30'(yp_next >> 30);
                sh_reg[k+1] <= Q30_ONE - 31'(30'(qp_next >> SIN_S[k]));
            end
        end
    end

    logic [60:0] sp_next;
    logic [30:0] c_sel, s_sel;
    assign sp_next = 61'(ang_reg[8].t) * 61'(sh_reg[4]);
    assign c_sel   = ang_reg[10].swap ? spad_reg : ch_reg[5];
    assign s_sel   = ang_reg[10].swap ? ch_reg[5] : spad_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sfin_reg    <= 31'(sp_next >> 30);
            spad_reg    <= sfin_reg;
            out_reg.neg <= (ang_reg[10].q == 2'd1) || (ang_reg[10].q == 2'd2);
            out_reg.mag <= ang_reg[10].q[0] ? s_sel : c_sel;
        end
    end

    assign out_cos = out_reg;

endmodule

### hw/rtl/bmg_scale.sv
module bmg_scale (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  bmg_pkg::bmg_root_t radius,
    input  bmg_pkg::bmg_cos_t  cosine,
    output bmg_pkg::bmg_res_t  out_item
);
    import bmg_pkg::*;

    logic        valid1_reg, valid2_reg;
    logic        neg1_reg;
    logic [62:0] prod_reg;
    logic [15:0] value_reg;

    logic [62:0] rnd_next;
    logic [17:0] mag_next;

    assign rnd_next = prod_reg + (63'd1 << (SCALE_SH - 1));
    assign mag_next = 18'(rnd_next >> SCALE_SH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= radius.valid;
            valid2_reg <= valid1_reg;
        end
    end

    // round half away from zero on the magnitude, then sign and clamp
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 63'(radius.root) * 63'(cosine.mag);
            neg1_reg <= cosine.neg;
            if (neg1_reg) begin
                value_reg <= (mag_next > 18'd32768) ? 16'h8000 : 16'(18'd0 - mag_next);
            end else begin
                value_reg <= (mag_next > 18'd32767) ? 16'h7fff : mag_next[15:0];
            end
        end
    end

    assign out_item.valid = valid2_reg;
    assign out_item.value = value_reg;

endmodule

### hw/rtl/box_muller_gaussian_unit.sv
// channel   dir  beat fields (low bit up)                 handshake
// s_        in   u_radius[31:0], u_angle[63:32]           s_tvalid / s_tready
// m_        out  gauss_value[15:0]                        m_tvalid / m_tready
// cfg_      in   u1_floor[31:0]                           cfg_valid / cfg_ready
//
// one beat per clock sustained while the skid is empty; an input beat reaches
// m_tvalid through 31 log stages, 32 square root stages, 2 scaling stages and one
// output register. an input below u1_floor or equal to zero is
// dropped. reset is synchronous active low and clears all valid bits; u1_floor
// resets to 1. a one-beat skid behind the output register lets the pipeline
// run while a result waits; s_tready drops only when that skid is occupied.
module box_muller_gaussian_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // u_radius[31:0], u_angle[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // gauss_value[15:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // u1_floor[31:0]
);
    import bmg_pkg::*;

    logic [31:0] floor_reg;
    logic        en;
    bmg_in_t     in_item;
    bmg_r2_t     r2_item;
    bmg_root_t   root_item;
    bmg_cos_t    cos_item;
    bmg_cos_t    align_reg [0:ALIGN_LAT-1];
    bmg_res_t    pipe_item;
    logic        out_valid_reg, skid_valid_reg;
    logic [15:0] out_data_reg, skid_data_reg;
    logic        take;

    assign cfg_ready = 1'b1;
    assign en        = !skid_valid_reg;
    assign s_tready  = en;
    assign take      = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= 32'd1;
        end else if (cfg_valid) begin
            floor_reg <= cfg_data;
        end
    end

    assign in_item.valid = s_tvalid && (s_tdata[31:0] != 32'd0) && (s_tdata[31:0] >= floor_reg);
    assign in_item.x     = s_tdata[31:0];

    bmg_log_unit u_log (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_item  (in_item),
        .out_item (r2_item)
    );

    bmg_sqrt_unit u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_item  (r2_item),
        .out_item (root_item)
    );

    bmg_cos_unit u_cos (
        .aclk    (aclk),
        .en      (en),
        .angle   (s_tdata[63:32]),
        .out_cos (cos_item)
    );

    // hold the cosine until the radius catches up
    always_ff @(posedge aclk) begin
        if (en) begin
            align_reg[0] <= cos_item;
            for (int k = 1; k < ALIGN_LAT; k++) align_reg[k] <= align_reg[k-1];
        end
    end

    bmg_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .radius   (root_item),
        .cosine   (align_reg[ALIGN_LAT-1]),
        .out_item (pipe_item)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (pipe_item.valid) begin
            if (out_valid_reg && !m_tready) skid_valid_reg <= 1'b1;
            else                            out_valid_reg  <= 1'b1;
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) out_data_reg <= skid_data_reg;
        end else if (pipe_item.valid) begin
            if (out_valid_reg && !m_tready) skid_data_reg <= pipe_item.value;
            else                            out_data_reg  <= pipe_item.value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### hw/rtl/bmg_checker.sv
module bmg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side blocks only while a result is waiting
    a_block_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input blocked with no result waiting");

    // skid fills only behind a stalled result
    a_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input blocked without output stall");

    // skid drains only when a result is taken
    a_drain_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_tready) && $past(aresetn) |-> $past(m_tvalid && m_tready))
        else $error("input unblocked without output beat");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output not empty after reset");

endmodule

bind box_muller_gaussian_unit bmg_checker u_bmg_checker (.*);
